@@ sv/bcrr_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the rank/unrank block.
`timescale 1ns / 1ps
package bcrr_pkg;

  localparam int MAX_SITES_DEF = 32;
  localparam int MAX_TOTAL_DEF = 63;
  localparam int IDX_W = 63;
  localparam int OCC_W = 6;
  localparam int CFG_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam int ERR_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_INEQ  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SITES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXOC = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd3;

  localparam logic OPC_ENC  = 1'b0;
  localparam logic OPC_DEC  = 1'b1;
  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;

  localparam logic [ERR_W-1:0] ERR_OK  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OVF = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OCC = 2'd2;
  localparam logic [ERR_W-1:0] ERR_IDX = 2'd3;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_BINIT, OP_BROW0, OP_BCELL, OP_BRD, OP_BADD,
    OP_TINIT, OP_TRD, OP_TADD, OP_ECHECK, OP_ERD, OP_EADD, OP_ESTEP,
    OP_EIINIT, OP_EIRD, OP_EIADD, OP_EEMIT, OP_DERR, OP_DINIT, OP_DSRD,
    OP_DSCMP, OP_DSITE, OP_DXRD, OP_DXCMP, OP_DXFIN, OP_DEMIT
  } cmd_t;

  typedef struct packed {
    logic tready;
    logic tovf;
    logic k_last;
    logic n_one;
    logic j_last;
    logic i_stop;
    logic add_ovf;
    logic e_loop;
    logic e_stop;
    logic last_site;
    logic opcode;
    logic ei_loop;
    logic ei_stop;
    logic idx_big;
    logic ineq;
    logic ds_end;
    logic d_ge;
    logic nn_last;
    logic x_over;
    logic out_free;
  } status_t;

endpackage

@@ sv/bcrr_ctrl.sv @@
// Sequencing state machine for table build, encode and decode.
`timescale 1ns / 1ps
module bcrr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  bcrr_pkg::status_t st,
  output bcrr_pkg::cmd_t   cmd,
  output logic             busy
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_BINIT = 5'd2;
  localparam logic [4:0] S_BROW0 = 5'd3;
  localparam logic [4:0] S_BCELL = 5'd4;
  localparam logic [4:0] S_BRD   = 5'd5;
  localparam logic [4:0] S_BADD  = 5'd6;
  localparam logic [4:0] S_TINIT = 5'd7;
  localparam logic [4:0] S_TRD   = 5'd8;
  localparam logic [4:0] S_TADD  = 5'd9;
  localparam logic [4:0] S_ERD   = 5'd10;
  localparam logic [4:0] S_EADD  = 5'd11;
  localparam logic [4:0] S_ESTEP = 5'd12;
  localparam logic [4:0] S_EFIN  = 5'd13;
  localparam logic [4:0] S_EIRD  = 5'd14;
  localparam logic [4:0] S_EIADD = 5'd15;
  localparam logic [4:0] S_EEMIT = 5'd16;
  localparam logic [4:0] S_DERR  = 5'd17;
  localparam logic [4:0] S_DSRD  = 5'd18;
  localparam logic [4:0] S_DSCMP = 5'd19;
  localparam logic [4:0] S_DSITE = 5'd20;
  localparam logic [4:0] S_DXRD  = 5'd21;
  localparam logic [4:0] S_DXCMP = 5'd22;
  localparam logic [4:0] S_DXFIN = 5'd23;
  localparam logic [4:0] S_DEMIT = 5'd24;

  logic [4:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = bcrr_pkg::OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd = bcrr_pkg::OP_LOAD;
          state_nxt = st.tready ? S_DISP : S_BINIT;
        end
      end
      S_BINIT: begin
        cmd = bcrr_pkg::OP_BINIT;
        state_nxt = S_BROW0;
      end
      S_BROW0: begin
        cmd = bcrr_pkg::OP_BROW0;
        if (st.k_last) state_nxt = st.n_one ? S_TINIT : S_BCELL;
      end
      S_BCELL: begin
        cmd = bcrr_pkg::OP_BCELL;
        state_nxt = S_BRD;
      end
      S_BRD: begin
        cmd = bcrr_pkg::OP_BRD;
        state_nxt = S_BADD;
      end
      S_BADD: begin
        cmd = bcrr_pkg::OP_BADD;
        if (st.add_ovf) state_nxt = S_DISP;
        else if (st.i_stop) state_nxt = (st.k_last && st.j_last) ? S_TINIT : S_BCELL;
        else state_nxt = S_BRD;
      end
      S_TINIT: begin
        cmd = bcrr_pkg::OP_TINIT;
        state_nxt = S_TRD;
      end
      S_TRD: begin
        cmd = bcrr_pkg::OP_TRD;
        state_nxt = S_TADD;
      end
      S_TADD: begin
        cmd = bcrr_pkg::OP_TADD;
        if (!st.ineq || st.add_ovf || st.k_last) state_nxt = S_DISP;
        else state_nxt = S_TRD;
      end
      S_DISP: begin
        if (st.opcode == bcrr_pkg::OPC_ENC) begin
          cmd = bcrr_pkg::OP_ECHECK;
          state_nxt = st.e_loop ? S_ERD : S_ESTEP;
        end else if (st.tovf || st.idx_big) begin
          state_nxt = S_DERR;
        end else begin
          cmd = bcrr_pkg::OP_DINIT;
          state_nxt = st.ineq ? S_DSRD : S_DSITE;
        end
      end
      S_ERD: begin
        cmd = bcrr_pkg::OP_ERD;
        state_nxt = S_EADD;
      end
      S_EADD: begin
        cmd = bcrr_pkg::OP_EADD;
        state_nxt = st.e_stop ? S_ESTEP : S_ERD;
      end
      S_ESTEP: begin
        cmd = bcrr_pkg::OP_ESTEP;
        state_nxt = st.last_site ? S_EFIN : S_IDLE;
      end
      S_EFIN: begin
        if (st.ei_loop) begin
          cmd = bcrr_pkg::OP_EIINIT;
          state_nxt = S_EIRD;
        end else begin
          state_nxt = S_EEMIT;
        end
      end
      S_EIRD: begin
        cmd = bcrr_pkg::OP_EIRD;
        state_nxt = S_EIADD;
      end
      S_EIADD: begin
        cmd = bcrr_pkg::OP_EIADD;
        state_nxt = st.ei_stop ? S_EEMIT : S_EIRD;
      end
      S_EEMIT: begin
        if (st.out_free) begin
          cmd = bcrr_pkg::OP_EEMIT;
          state_nxt = S_IDLE;
        end
      end
      S_DERR: begin
        if (st.out_free) begin
          cmd = bcrr_pkg::OP_DERR;
          state_nxt = S_IDLE;
        end
      end
      S_DSRD: begin
        if (st.ds_end) begin
          state_nxt = S_DSITE;
        end else begin
          cmd = bcrr_pkg::OP_DSRD;
          state_nxt = S_DSCMP;
        end
      end
      S_DSCMP: begin
        cmd = bcrr_pkg::OP_DSCMP;
        state_nxt = st.d_ge ? S_DSRD : S_DSITE;
      end
      S_DSITE: begin
        cmd = bcrr_pkg::OP_DSITE;
        state_nxt = st.nn_last ? S_DEMIT : S_DXRD;
      end
      S_DXRD: begin
        if (st.x_over) begin
          state_nxt = S_DXFIN;
        end else begin
          cmd = bcrr_pkg::OP_DXRD;
          state_nxt = S_DXCMP;
        end
      end
      S_DXCMP: begin
        cmd = bcrr_pkg::OP_DXCMP;
        state_nxt = st.d_ge ? S_DXRD : S_DXFIN;
      end
      S_DXFIN: begin
        cmd = bcrr_pkg::OP_DXFIN;
        state_nxt = S_DEMIT;
      end
      S_DEMIT: begin
        if (st.out_free) begin
          cmd = bcrr_pkg::OP_DEMIT;
          state_nxt = st.nn_last ? S_IDLE : S_DSITE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

@@ sv/bcrr_dp.sv @@
// Datapath: configuration, count table memory, encode/decode registers and output register.
`timescale 1ns / 1ps
module bcrr_dp #(
  parameter int MAX_SITES = bcrr_pkg::MAX_SITES_DEF,
  parameter int MAX_TOTAL = bcrr_pkg::MAX_TOTAL_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bcrr_pkg::cmd_t                  cmd,
  output bcrr_pkg::status_t               st,
  input  logic                            in_opcode,
  input  logic [bcrr_pkg::OCC_W-1:0]      in_occupation,
  input  logic                            in_last_site,
  input  logic [bcrr_pkg::IDX_W-1:0]      in_state_index,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bcrr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcrr_pkg::CFG_W-1:0]      cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_result_kind,
  output logic [bcrr_pkg::IDX_W-1:0]      out_index_out,
  output logic [bcrr_pkg::OCC_W-1:0]      out_occupation_out,
  output logic                            out_last_out,
  output logic [bcrr_pkg::IDX_W-1:0]      out_total_states,
  output logic [bcrr_pkg::ERR_W-1:0]      out_error_code
);

  localparam int IW = bcrr_pkg::IDX_W;
  localparam int OW = bcrr_pkg::OCC_W;
  localparam int NW = $clog2(MAX_SITES + 1);
  localparam int JW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int KW = $clog2(MAX_TOTAL + 1);
  localparam int CW = ((KW > OW) ? KW : OW) + 1;
  localparam int AW = JW + KW;
  localparam int DEPTH = 2 ** AW;

  // configuration
  logic          ineq_r;
  logic [OW-1:0] sites_r, maxoc_r, total_lim_r;
  logic [NW-1:0] eff_n;
  logic [OW-1:0] eff_m;
  logic [KW-1:0] eff_s;
  logic [6:0]    n_clip;
  logic [7:0]    s_clip;

  // table and build
  logic [IW-1:0] mem [DEPTH];
  logic [IW-1:0] rdata_r;
  logic [AW-1:0] raddr, waddr;
  logic [IW-1:0] wdata;
  logic          we;
  logic          tready_r, tovf_r;
  logic [IW-1:0] total_r, acc_r;
  logic [JW-1:0] j_r;
  logic [KW-1:0] k_r, i_r;
  logic [IW:0]   sum64;

  // item and encode/decode working state
  logic          op_r, last_r;
  logic [OW-1:0] occ_r;
  logic [IW-1:0] sidx_r, ridx_r;
  logic [KW-1:0] rsum_r, jj_r, dsum_r;
  logic [OW-1:0] pos_r;
  logic          eerr_r;
  logic [KW:0]   x_r, xm;
  logic [NW-1:0] nn_r;
  logic [CW-1:0] ns;
  logic          e_badc, e_bad;
  logic [JW-1:0] row_last;

  // output register
  logic          ovalid_r, okind_r, olast_r;
  logic [IW-1:0] oidx_r, ototal_r;
  logic [OW-1:0] oocc_r;
  logic [bcrr_pkg::ERR_W-1:0] oerr_r;
  logic          out_free;

  assign cfg_ready = 1'b1;

  assign n_clip = (sites_r == '0) ? 7'd1 :
                  (({1'b0, sites_r} > 7'(MAX_SITES)) ? 7'(MAX_SITES) : {1'b0, sites_r});
  assign s_clip = ({2'b0, total_lim_r} > 8'(MAX_TOTAL)) ? 8'(MAX_TOTAL) : {2'b0, total_lim_r};
  assign eff_n  = NW'(n_clip);
  assign eff_m  = maxoc_r;
  assign eff_s  = (maxoc_r == '0) ? '0 : KW'(s_clip);
  assign row_last = JW'(eff_n - NW'(1));

  assign sum64 = {1'b0, acc_r} + {1'b0, rdata_r};
  assign ns    = CW'(rsum_r) + CW'(occ_r);
  assign e_badc = (7'(pos_r) >= 7'(eff_n)) || (occ_r > eff_m) || (ns > CW'(eff_s));
  assign e_bad  = eerr_r || (7'(pos_r) != 7'(eff_n)) || (!ineq_r && (rsum_r != eff_s));
  assign xm     = (x_r > (KW+1)'(dsum_r)) ? (KW+1)'(dsum_r) : x_r;
  assign out_free = !ovalid_r || !out_stall;

  always_comb begin
    st.tready    = tready_r;
    st.tovf      = tovf_r;
    st.k_last    = (k_r == eff_s);
    st.n_one     = (eff_n == NW'(1));
    st.j_last    = ((NW+1)'(j_r) + (NW+1)'(1)) == (NW+1)'(eff_n);
    st.i_stop    = (CW'(i_r) == CW'(eff_m)) || (i_r == k_r);
    st.add_ovf   = sum64[IW];
    st.e_loop    = !eerr_r && !e_badc && (pos_r != '0) && !tovf_r && (occ_r != '0);
    st.e_stop    = (CW'(jj_r) + CW'(1)) == CW'(occ_r);
    st.last_site = last_r;
    st.opcode    = op_r;
    st.ei_loop   = ineq_r && (rsum_r != '0) && !tovf_r && !e_bad;
    st.ei_stop   = (jj_r + KW'(1)) == rsum_r;
    st.idx_big   = (sidx_r >= total_r);
    st.ineq      = ineq_r;
    st.ds_end    = (dsum_r == eff_s);
    st.d_ge      = (sidx_r >= rdata_r);
    st.nn_last   = (nn_r == eff_n);
    st.x_over    = (x_r > (KW+1)'(dsum_r));
    st.out_free  = out_free;
  end

  always_comb begin
    raddr = '0;
    case (cmd)
      bcrr_pkg::OP_BRD:  raddr = {JW'(j_r - JW'(1)), KW'(k_r - i_r)};
      bcrr_pkg::OP_TRD:  raddr = {row_last, ineq_r ? k_r : eff_s};
      bcrr_pkg::OP_ERD:  raddr = {JW'(pos_r - OW'(1)), KW'(rsum_r - jj_r)};
      bcrr_pkg::OP_EIRD: raddr = {row_last, jj_r};
      bcrr_pkg::OP_DSRD: raddr = {row_last, dsum_r};
      bcrr_pkg::OP_DXRD: raddr = {JW'(eff_n - nn_r - NW'(1)), KW'(dsum_r - KW'(x_r))};
      default:           raddr = '0;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = {j_r, k_r};
    wdata = '0;
    case (cmd)
      bcrr_pkg::OP_BROW0: begin
        we = 1'b1;
        waddr = {JW'(0), k_r};
        wdata = (CW'(k_r) <= CW'(eff_m)) ? IW'(1) : '0;
      end
      bcrr_pkg::OP_BADD: begin
        we = !sum64[IW] && st.i_stop;
        wdata = sum64[IW-1:0];
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  // build counters and working registers, no reset needed
  always_ff @(posedge clk) begin
    case (cmd)
      bcrr_pkg::OP_LOAD: begin
        op_r   <= in_opcode;
        occ_r  <= in_occupation;
        last_r <= in_last_site;
        sidx_r <= in_state_index;
      end
      bcrr_pkg::OP_BINIT: begin
        j_r <= '0;
        k_r <= '0;
      end
      bcrr_pkg::OP_BROW0: begin
        if (st.k_last) begin
          j_r <= JW'(1);
          k_r <= '0;
        end else begin
          k_r <= k_r + KW'(1);
        end
      end
      bcrr_pkg::OP_BCELL: begin
        acc_r <= '0;
        i_r   <= '0;
      end
      bcrr_pkg::OP_BADD: begin
        if (!sum64[IW]) begin
          if (st.i_stop) begin
            if (st.k_last) begin
              j_r <= j_r + JW'(1);
              k_r <= '0;
            end else begin
              k_r <= k_r + KW'(1);
            end
          end else begin
            acc_r <= sum64[IW-1:0];
            i_r   <= i_r + KW'(1);
          end
        end
      end
      bcrr_pkg::OP_TINIT: begin
        acc_r <= '0;
        k_r   <= '0;
      end
      bcrr_pkg::OP_TADD: begin
        acc_r <= sum64[IW-1:0];
        k_r   <= k_r + KW'(1);
      end
      bcrr_pkg::OP_ECHECK: jj_r <= '0;
      bcrr_pkg::OP_EADD:   jj_r <= jj_r + KW'(1);
      bcrr_pkg::OP_EIINIT: jj_r <= '0;
      bcrr_pkg::OP_EIADD:  jj_r <= jj_r + KW'(1);
      bcrr_pkg::OP_DINIT: begin
        dsum_r <= ineq_r ? '0 : eff_s;
        nn_r   <= NW'(1);
      end
      bcrr_pkg::OP_DSCMP: begin
        if (st.d_ge) begin
          sidx_r <= sidx_r - rdata_r;
          dsum_r <= dsum_r + KW'(1);
        end
      end
      bcrr_pkg::OP_DSITE: x_r <= st.nn_last ? (KW+1)'(dsum_r) : '0;
      bcrr_pkg::OP_DXCMP: begin
        if (st.d_ge) begin
          sidx_r <= sidx_r - rdata_r;
          x_r    <= x_r + (KW+1)'(1);
        end
      end
      bcrr_pkg::OP_DXFIN: begin
        x_r    <= xm;
        dsum_r <= dsum_r - KW'(xm);
      end
      bcrr_pkg::OP_DEMIT: nn_r <= nn_r + NW'(1);
      default: ;
    endcase
  end

  // configuration, table status and encode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ineq_r      <= 1'b0;
      sites_r     <= OW'(1);
      maxoc_r     <= OW'(1);
      total_lim_r <= OW'(1);
      tready_r    <= 1'b0;
      tovf_r      <= 1'b0;
      total_r     <= '0;
      ridx_r      <= '0;
      rsum_r      <= '0;
      pos_r       <= '0;
      eerr_r      <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        bcrr_pkg::CFG_INEQ:  ineq_r      <= cfg_data[0];
        bcrr_pkg::CFG_SITES: sites_r     <= cfg_data;
        bcrr_pkg::CFG_MAXOC: maxoc_r     <= cfg_data;
        bcrr_pkg::CFG_TOTAL: total_lim_r <= cfg_data;
        default: ;
      endcase
      tready_r <= 1'b0;
      ridx_r   <= '0;
      rsum_r   <= '0;
      pos_r    <= '0;
      eerr_r   <= 1'b0;
    end else begin
      case (cmd)
        bcrr_pkg::OP_BINIT: begin
          tready_r <= 1'b1;
          tovf_r   <= 1'b0;
          total_r  <= '0;
        end
        bcrr_pkg::OP_BADD: if (sum64[IW]) tovf_r <= 1'b1;
        bcrr_pkg::OP_TADD: begin
          if (!ineq_r) total_r <= rdata_r;
          else if (sum64[IW]) tovf_r <= 1'b1;
          else if (st.k_last) total_r <= sum64[IW-1:0];
        end
        bcrr_pkg::OP_ECHECK: begin
          if (!eerr_r) begin
            if (e_badc) eerr_r <= 1'b1;
            else rsum_r <= KW'(ns);
          end
        end
        bcrr_pkg::OP_EADD, bcrr_pkg::OP_EIADD: ridx_r <= ridx_r + rdata_r;
        bcrr_pkg::OP_ESTEP: if (pos_r != {OW{1'b1}}) pos_r <= pos_r + OW'(1);
        bcrr_pkg::OP_EEMIT: begin
          ridx_r <= '0;
          rsum_r <= '0;
          pos_r  <= '0;
          eerr_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd == bcrr_pkg::OP_EEMIT || cmd == bcrr_pkg::OP_DERR ||
                 cmd == bcrr_pkg::OP_DEMIT) begin
      ovalid_r <= 1'b1;
    end else if (!out_stall) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      bcrr_pkg::OP_EEMIT: begin
        okind_r  <= bcrr_pkg::KIND_ENC;
        oidx_r   <= (tovf_r || e_bad) ? '0 : ridx_r;
        oocc_r   <= '0;
        olast_r  <= 1'b1;
        ototal_r <= tovf_r ? '0 : total_r;
        oerr_r   <= tovf_r ? bcrr_pkg::ERR_OVF : (e_bad ? bcrr_pkg::ERR_OCC : bcrr_pkg::ERR_OK);
      end
      bcrr_pkg::OP_DERR: begin
        okind_r  <= bcrr_pkg::KIND_DEC;
        oidx_r   <= '0;
        oocc_r   <= '0;
        olast_r  <= 1'b1;
        ototal_r <= tovf_r ? '0 : total_r;
        oerr_r   <= tovf_r ? bcrr_pkg::ERR_OVF : bcrr_pkg::ERR_IDX;
      end
      bcrr_pkg::OP_DEMIT: begin
        okind_r  <= bcrr_pkg::KIND_DEC;
        oidx_r   <= '0;
        oocc_r   <= OW'(x_r);
        olast_r  <= st.nn_last;
        ototal_r <= total_r;
        oerr_r   <= bcrr_pkg::ERR_OK;
      end
      default: ;
    endcase
  end

  assign out_valid          = ovalid_r;
  assign out_result_kind    = okind_r;
  assign out_index_out      = oidx_r;
  assign out_occupation_out = oocc_r;
  assign out_last_out       = olast_r;
  assign out_total_states   = ototal_r;
  assign out_error_code     = oerr_r;

endmodule

@@ sv/bounded_composition_rank_unrank_top.sv @@
// Top level of the bounded composition rank/unrank block.
`timescale 1ns / 1ps
// One item at a time through a controller and a datapath around a single-port-read
// count table (one registered read per cycle). After reset or any configuration write,
// the first item first builds the table, then finds the total. An encode transaction
// checks the occupation, adds one table read per occupation unit and steps the site;
// on the last site in inequality mode it also adds the table reads up to the sum. A
// decode first searches for the total in inequality mode, then for each site's
// occupation; each table compare is a read state followed by a compare state.
// Output waits on out_stall.
module bounded_composition_rank_unrank_top #(
  parameter int MAX_SITES = bcrr_pkg::MAX_SITES_DEF,
  parameter int MAX_TOTAL = bcrr_pkg::MAX_TOTAL_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_opcode,
  input  logic [bcrr_pkg::OCC_W-1:0]      in_occupation,
  input  logic                            in_last_site,
  input  logic [bcrr_pkg::IDX_W-1:0]      in_state_index,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bcrr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcrr_pkg::CFG_W-1:0]      cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_result_kind,
  output logic [bcrr_pkg::IDX_W-1:0]      out_index_out,
  output logic [bcrr_pkg::OCC_W-1:0]      out_occupation_out,
  output logic                            out_last_out,
  output logic [bcrr_pkg::IDX_W-1:0]      out_total_states,
  output logic [bcrr_pkg::ERR_W-1:0]      out_error_code
);

  bcrr_pkg::cmd_t    cmd;
  bcrr_pkg::status_t st;
  logic              busy;

  assign in_stall = busy;

  bcrr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .cmd      (cmd),
    .busy     (busy)
  );

  bcrr_dp #(
    .MAX_SITES (MAX_SITES),
    .MAX_TOTAL (MAX_TOTAL)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_opcode          (in_opcode),
    .in_occupation      (in_occupation),
    .in_last_site       (in_last_site),
    .in_state_index     (in_state_index),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_index_out      (out_index_out),
    .out_occupation_out (out_occupation_out),
    .out_last_out       (out_last_out),
    .out_total_states   (out_total_states),
    .out_error_code     (out_error_code)
  );

endmodule

@@ sv/bcrr_checker.sv @@
// Port-level checker for the rank/unrank block, bound to the top level.
`timescale 1ns / 1ps
module bcrr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_result_kind,
  input logic [bcrr_pkg::IDX_W-1:0]      out_index_out,
  input logic [bcrr_pkg::OCC_W-1:0]      out_occupation_out,
  input logic                            out_last_out,
  input logic [bcrr_pkg::ERR_W-1:0]      out_error_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_index_out) &&
    $stable(out_occupation_out) && $stable(out_error_code))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken before first finished");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != bcrr_pkg::ERR_OK |->
    out_last_out && out_index_out == '0 && out_occupation_out == '0)
    else $error("error result not a clean final result");

  a_enc_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == bcrr_pkg::KIND_ENC |->
    out_last_out && out_occupation_out == '0 && out_error_code != bcrr_pkg::ERR_IDX)
    else $error("malformed encode result");

endmodule

bind bounded_composition_rank_unrank_top bcrr_checker u_bcrr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_result_kind    (out_result_kind),
  .out_index_out      (out_index_out),
  .out_occupation_out (out_occupation_out),
  .out_last_out       (out_last_out),
  .out_error_code     (out_error_code)
);
